@@ hw/rtl/lrse_pkg.sv @@
// lrse_pkg: shared constants, types and helpers for the life row stencil engine
// used by every module under hw/rtl; no dependencies of its own
`timescale 1ns / 1ps
`default_nettype none

package lrse_pkg;

    // grid geometry and lane split
    localparam int RowWidth  = 64;
    localparam int Lanes     = 8;
    localparam int LaneW     = RowWidth / Lanes;
    localparam int LaneCntW  = $clog2(LaneW + 1);
    localparam int CountW    = $clog2(RowWidth + 1);
    localparam int ColsW     = 7;

    localparam logic [ColsW-1:0] ColsReset = ColsW'(RowWidth);

    // one stencil request: three rows and the end-of-frame mark
    typedef struct packed {
        logic [RowWidth-1:0] above;
        logic [RowWidth-1:0] mid;
        logic [RowWidth-1:0] below;
        logic                frame_end;
    } job_t;

    // what one lane found for its slice of columns
    typedef struct packed {
        logic [LaneW-1:0]    cells;
        logic [LaneCntW-1:0] count;
        logic                changed;
    } lane_res_t;

    // columns at or above the column count are dead
    function automatic logic [RowWidth-1:0] col_mask(input logic [ColsW-1:0] cols);
        logic [RowWidth-1:0] m;
        for (int k = 0; k < RowWidth; k++)
        begin
            m[k] = (int'(cols) > k);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lrse_lane.sv @@
// lrse_lane: B3/S23 rule for one slice of columns, with a halo column on each side
// depends on lrse_pkg for the lane width and the lane result type
`timescale 1ns / 1ps
`default_nettype none

module lrse_lane
    import lrse_pkg::*;
(
    input  wire logic [LaneW+1:0] above,
    input  wire logic [LaneW+1:0] mid,
    input  wire logic [LaneW+1:0] below,
    input  wire logic [LaneW-1:0] mask,
    output lane_res_t             res
);

    // neighbor sums and the birth / survival rule per cell
    always_comb
    begin
        logic [3:0]          sum;
        logic [LaneW-1:0]    nx;
        logic [LaneCntW-1:0] cnt;
        nx  = '0;
        cnt = '0;
        for (int c = 0; c < LaneW; c++)
        begin
            sum = 4'(above[c]) + 4'(above[c+1]) + 4'(above[c+2])
                + 4'(mid[c]) + 4'(mid[c+2])
                + 4'(below[c]) + 4'(below[c+1]) + 4'(below[c+2]);
            nx[c] = mask[c] && ((sum == 4'd3) || (mid[c+1] && (sum == 4'd2)));
        end
        // live count of the slice
        for (int c = 0; c < LaneW; c++)
        begin
            cnt = cnt + LaneCntW'(nx[c]);
        end
        res.cells   = nx;
        res.count   = cnt;
        res.changed = |(nx ^ mid[LaneW:1]);
    end

endmodule

`default_nettype wire

@@ hw/rtl/lrse_feed.sv @@
// lrse_feed: row history, frame tracking and the stencil request register
// depends on lrse_pkg for job_t; splits a bottom row below an earlier row into two requests
`timescale 1ns / 1ps
`default_nettype none

module lrse_feed
    import lrse_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [RowWidth-1:0] row_masked,
    input  wire logic                first_row,
    input  wire logic                final_row,
    input  wire logic                job_ready,
    output logic                     job_valid,
    output job_t                     job
);

    logic          mid_valid_reg, mid_valid_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          job_valid_reg, job_valid_next;
    logic [RowWidth-1:0] above_reg, above_next;
    logic [RowWidth-1:0] mid_reg, mid_next;
    job_t          pend_reg, pend_next;
    job_t          job_reg, job_next;
    logic          slot_ready;
    logic          in_acc;
    logic          start;

    // request slot frees when empty or drained into the lanes
    assign slot_ready = !job_valid_reg || job_ready;
    assign in_stall   = pend_valid_reg || !slot_ready;
    assign in_acc     = in_valid && !in_stall;
    assign start      = first_row || !mid_valid_reg;

    // row history and request sequencing
    always_comb
    begin
        mid_valid_next  = mid_valid_reg;
        pend_valid_next = pend_valid_reg;
        job_valid_next  = job_valid_reg;
        above_next      = above_reg;
        mid_next        = mid_reg;
        pend_next       = pend_reg;
        job_next        = job_reg;

        if (in_acc)
        begin
            if (start)
            begin
                above_next = '0;
            end
            else
            begin
                above_next = mid_reg;
            end
            mid_next       = row_masked;
            mid_valid_next = !final_row;
        end

        if (slot_ready)
        begin
            priority if (pend_valid_reg)
            begin
                job_next        = pend_reg;
                job_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (in_acc && !start)
            begin
                job_next       = '{above: above_reg, mid: mid_reg, below: row_masked,
                                   frame_end: 1'b0};
                job_valid_next = 1'b1;
                if (final_row)
                begin
                    pend_next       = '{above: mid_reg, mid: row_masked, below: '0,
                                        frame_end: 1'b1};
                    pend_valid_next = 1'b1;
                end
            end
            else if (in_acc && final_row)
            begin
                job_next       = '{above: '0, mid: row_masked, below: '0, frame_end: 1'b1};
                job_valid_next = 1'b1;
            end
            else
            begin
                job_valid_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            job_valid_reg  <= 1'b0;
        end
        else
        begin
            mid_valid_reg  <= mid_valid_next;
            pend_valid_reg <= pend_valid_next;
            job_valid_reg  <= job_valid_next;
        end
    end

    // row and request payload
    always_ff @(posedge clk)
    begin
        above_reg <= above_next;
        mid_reg   <= mid_next;
        pend_reg  <= pend_next;
        job_reg   <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

`ifndef ASSERT_OFF
    // a held second request always sits behind a first one in the slot
    a_pend_behind_job: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> job_valid_reg)
        else $error("pending request without a request in the slot");

    // a bottom-row request always looks at a dead row below
    a_end_below_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && job_reg.frame_end) |-> (job_reg.below == '0))
        else $error("frame end request with live row below");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/lrse_merge.sv @@
// lrse_merge: registers the lane results, merges counts and change flags,
// and holds the output register; depends on lrse_pkg for lane_res_t
`timescale 1ns / 1ps
`default_nettype none

module lrse_merge
    import lrse_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 lane_valid,
    output logic                      lane_ready,
    input  lane_res_t [Lanes-1:0]     lane_res,
    input  wire logic                 lane_end,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [RowWidth-1:0]       next_row,
    output logic                      row_changed,
    output logic [CountW-1:0]         live_count,
    output logic                      frame_end
);

    logic                   s2_valid_reg, s2_valid_next;
    lane_res_t [Lanes-1:0]  s2_res_reg;
    logic                   s2_end_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [RowWidth-1:0]    row_reg;
    logic                   changed_reg;
    logic [CountW-1:0]      count_reg;
    logic                   end_reg;
    logic                   out_ready;
    logic                   s2_ready;
    logic [RowWidth-1:0]    row_sum;
    logic                   changed_sum;
    logic [CountW-1:0]      count_sum;

    // ready chain back from the output register
    assign out_ready  = !out_valid_reg || !out_stall;
    assign s2_ready   = !s2_valid_reg || out_ready;
    assign lane_ready = s2_ready;

    always_comb
    begin
        s2_valid_next  = s2_ready ? lane_valid : s2_valid_reg;
        out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;
    end

    // merge of the lane results
    always_comb
    begin
        row_sum     = '0;
        changed_sum = 1'b0;
        count_sum   = '0;
        for (int i = 0; i < Lanes; i++)
        begin
            row_sum[i*LaneW +: LaneW] = s2_res_reg[i].cells;
            changed_sum = changed_sum | s2_res_reg[i].changed;
            count_sum   = count_sum + CountW'(s2_res_reg[i].count);
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_res_reg <= lane_res;
            s2_end_reg <= lane_end;
        end
        if (out_ready)
        begin
            row_reg     <= row_sum;
            changed_reg <= changed_sum;
            count_reg   <= count_sum;
            end_reg     <= s2_end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_row    = row_reg;
    assign row_changed = changed_reg;
    assign live_count  = count_reg;
    assign frame_end   = end_reg;

`ifndef ASSERT_OFF
    // merged count agrees with the merged row
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (int'(count_reg) == $countones(row_reg)))
        else $error("live count does not match next row");

    // a row never holds more live cells than columns
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (int'(count_reg) <= RowWidth))
        else $error("live count out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/life_row_stencil_engine_unit.sv @@
// life_row_stencil_engine_unit: top level of the life row stencil engine
// depends on lrse_pkg, lrse_feed, lrse_lane and lrse_merge
//
// One generation of the B3/S23 automaton on a grid with dead borders.
// Input channel (in_valid / in_stall): one row of the current generation
// per request, first_row opens a frame, final_row closes it. A row without
// an open frame starts one. Each row after the top one yields the result
// for the row above it; the bottom row yields one more result, with
// frame_end set. Output channel (out_valid / out_stall) carries next_row,
// row_changed and live_count. Config channel (cfg_valid / cfg_ready)
// writes columns_in_use; write it only while no result is outstanding.
// Rows are taken one per cycle while out_stall stays low, except that a bottom
// row that ends a frame of two or more rows holds in_stall while its second
// result enters the lanes. A result passes through the request slot, the lane
// register and the output register in that order; a bottom row's second result
// follows right behind the first. Eight lanes of eight columns run in parallel.
// Reset empties the pipeline, closes any frame and sets 64 columns.
// A stalled output holds its result; the stages behind it keep filling
// until full, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module life_row_stencil_engine_unit
    import lrse_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [ColsW-1:0]    columns_in_use,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [RowWidth-1:0] row_cells,
    input  wire logic                first_row,
    input  wire logic                final_row,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [RowWidth-1:0]      next_row,
    output logic                     row_changed,
    output logic [CountW-1:0]        live_count,
    output logic                     frame_end
);

    logic [ColsW-1:0]      cols_reg, cols_next;
    logic [RowWidth-1:0]   mask;
    logic [RowWidth-1:0]   row_masked;
    logic                  job_valid;
    logic                  job_ready;
    job_t                  job;
    logic [RowWidth+1:0]   above_pad;
    logic [RowWidth+1:0]   mid_pad;
    logic [RowWidth+1:0]   below_pad;
    lane_res_t [Lanes-1:0] lane_res;

    // column count register
    assign cfg_ready = 1'b1;
    assign cols_next = (cfg_valid && cfg_ready) ? columns_in_use : cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= ColsReset;
        end
        else
        begin
            cols_reg <= cols_next;
        end
    end

    assign mask       = col_mask(cols_reg);
    assign row_masked = row_cells & mask;

    // row history and request slot
    lrse_feed u_feed (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row_masked (row_masked),
        .first_row  (first_row),
        .final_row  (final_row),
        .job_ready  (job_ready),
        .job_valid  (job_valid),
        .job        (job)
    );

    // masked rows with a dead column on each side
    assign above_pad = {1'b0, job.above & mask, 1'b0};
    assign mid_pad   = {1'b0, job.mid & mask, 1'b0};
    assign below_pad = {1'b0, job.below & mask, 1'b0};

    // stencil lanes
    for (genvar i = 0; i < Lanes; i++)
    begin : g_lane
        lrse_lane u_lane (
            .above (above_pad[i*LaneW +: LaneW+2]),
            .mid   (mid_pad[i*LaneW +: LaneW+2]),
            .below (below_pad[i*LaneW +: LaneW+2]),
            .mask  (mask[i*LaneW +: LaneW]),
            .res   (lane_res[i])
        );
    end

    // merge and output register
    lrse_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lane_valid  (job_valid),
        .lane_ready  (job_ready),
        .lane_res    (lane_res),
        .lane_end    (job.frame_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_row    (next_row),
        .row_changed (row_changed),
        .live_count  (live_count),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire

@@ bench/life_row_stencil_engine_unit_test.sv @@
// life_row_stencil_engine_unit_test: self-checking bench for the life row stencil engine
// depends on lrse_pkg and life_row_stencil_engine_unit; every next-generation row is
// checked field by field against a B3/S23 predictor in this file or a typed table row
`timescale 1ns / 1ps

module life_row_stencil_engine_unit_test
    import lrse_pkg::*;
();

    localparam int IdleLimit   = 4000;
    localparam int DrainWait   = 6;
    localparam int TailWait    = 20;
    localparam int HoldCycles  = 64;
    localparam int DirCount    = 25;
    localparam int PhaseCount  = 10;
    localparam int PhaseRows   = 50;
    localparam int PressureRow = 40;

    // one next-generation row as the block reports it
    typedef struct {
        logic [RowWidth-1:0] cells;
        logic                changed;
        logic [CountW-1:0]   count;
        logic                last;
    } gen_row_t;

    // one directed request; the typed result holds for single-row frames only
    typedef struct packed {
        logic [RowWidth-1:0] cells;
        logic                top;
        logic                bottom;
        logic                typed;
        logic [RowWidth-1:0] exp_cells;
        logic                exp_changed;
        logic [CountW-1:0]   exp_count;
    } dir_row_t;

    typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_t;
    typedef enum int {StyleRandom, StyleSparse, StyleDense, StyleUniform, StyleShape} cell_style_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ColsW-1:0]    columns_in_use = ColsReset;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [RowWidth-1:0] row_cells = '0;
    logic                first_row = 1'b0;
    logic                final_row = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [RowWidth-1:0] next_row;
    logic                row_changed;
    logic [CountW-1:0]   live_count;
    logic                frame_end;

    // predictor state
    logic [RowWidth-1:0] held_above = '0;
    logic [RowWidth-1:0] held_row = '0;
    logic                frame_open = 1'b0;
    logic [ColsW-1:0]    cols_setting = ColsReset;
    gen_row_t            expected_rows [$];
    gen_row_t            head;

    // sender and receiver pacing
    bit                  steady_send = 1'b0;
    int                  burst_left = 0;
    bit                  hold_req = 1'b0;
    int                  hold_left = 0;
    stall_mode_t         stall_mode = StallNone;
    int                  mode_left = 0;
    int                  stall_tick = 0;

    // bookkeeping
    int                  errors = 0;
    int                  rows_sent = 0;
    int                  results_seen = 0;
    int                  frame_ends = 0;
    int                  cfg_writes = 0;
    int                  stall_cycles = 0;
    int                  holds_done = 0;
    int                  idle_cycles = 0;

    // directed rows: edge cells, blinker, block, glider, abandoned frame,
    // rows without an open frame, top-and-bottom row while a frame is open
    dir_row_t dir_rows [DirCount] = '{
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 7'd62},
        '{64'h0, 1'b1, 1'b1, 1'b1, 64'h0, 1'b0, 7'd0},
        '{64'h7, 1'b1, 1'b1, 1'b1, 64'h2, 1'b1, 7'd1},
        '{64'hE000_0000_0000_0000, 1'b1, 1'b1, 1'b1, 64'h4000_0000_0000_0000, 1'b1, 7'd1},
        '{64'h1, 1'b1, 1'b1, 1'b1, 64'h0, 1'b1, 7'd0},
        '{64'h2, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h2, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h2, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h18, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h18, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'hFF, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'hF0F0, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h3C, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h3C, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'hFFFF_0000_FFFF_0000, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h1234, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 7'd62},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h2, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h4, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0, 7'd0},
        '{64'h7, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0, 7'd0}
    };

    life_row_stencil_engine_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .columns_in_use (columns_in_use),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .row_cells      (row_cells),
        .first_row      (first_row),
        .final_row      (final_row),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .next_row       (next_row),
        .row_changed    (row_changed),
        .live_count     (live_count),
        .frame_end      (frame_end)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // live columns for a column count; counts past the row width mean all
    function automatic logic [RowWidth-1:0] cols_to_mask(input logic [ColsW-1:0] cols);
        if (cols >= RowWidth)
            return {RowWidth{1'b1}};
        return (64'd1 << cols) - 64'd1;
    endfunction

    // one B3/S23 generation of the middle row, dead outside the mask
    function automatic gen_row_t life_next_row(input logic [RowWidth-1:0] above,
                                               input logic [RowWidth-1:0] mid,
                                               input logic [RowWidth-1:0] below,
                                               input logic last,
                                               input logic [RowWidth-1:0] mask);
        gen_row_t            r;
        logic [RowWidth-1:0] a;
        logic [RowWidth-1:0] m;
        logic [RowWidth-1:0] b;
        logic [RowWidth-1:0] nx;
        int                  nb;
        a = above & mask;
        m = mid & mask;
        b = below & mask;
        nx = '0;
        for (int k = 0; k < RowWidth; k++)
        begin
            nb = int'(a[k]) + int'(b[k]);
            if (k > 0)
                nb += int'(a[k-1]) + int'(m[k-1]) + int'(b[k-1]);
            if (k < RowWidth - 1)
                nb += int'(a[k+1]) + int'(m[k+1]) + int'(b[k+1]);
            nx[k] = (nb == 3) || (m[k] && nb == 2);
        end
        nx &= mask;
        r.cells = nx;
        r.changed = (nx != m);
        r.count = CountW'($countones(nx));
        r.last = last;
        return r;
    endfunction

    // advance the frame by one accepted row and queue the rows it completes
    task automatic predict_row(input logic [RowWidth-1:0] cells, input logic top,
                               input logic bottom);
        logic [RowWidth-1:0] mask;
        logic [RowWidth-1:0] row;
        mask = cols_to_mask(cols_setting);
        row = cells & mask;
        if (top || !frame_open)
        begin
            held_above = '0;
            held_row = row;
            frame_open = 1'b1;
        end
        else
        begin
            expected_rows.push_back(life_next_row(held_above, held_row, row, 1'b0, mask));
            held_above = held_row;
            held_row = row;
        end
        if (bottom)
        begin
            expected_rows.push_back(life_next_row(held_above, held_row, '0, 1'b1, mask));
            frame_open = 1'b0;
        end
    endtask

    function automatic logic [RowWidth-1:0] random_cells(input cell_style_t style);
        logic [RowWidth-1:0] a;
        logic [RowWidth-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case (style)
            StyleRandom: return a;
            StyleSparse: return a & b & {$urandom, $urandom};
            StyleDense:  return a | b;
            StyleUniform: return ($urandom_range(0, 1) != 0) ? {RowWidth{1'b1}} : '0;
            default:     return {60'd0, a[3:0]} << $urandom_range(0, 60);
        endcase
    endfunction

    // offer one row request, then idle between bursts
    task automatic offer_row(input logic [RowWidth-1:0] cells, input logic top,
                             input logic bottom, input logic typed, input gen_row_t typed_res);
        in_valid <= 1'b1;
        row_cells <= cells;
        first_row <= top;
        final_row <= bottom;
        do @(posedge clk); while (in_stall);
        predict_row(cells, top, bottom);
        if (typed)
        begin
            void'(expected_rows.pop_back());
            expected_rows.push_back(typed_res);
        end
        rows_sent++;
        if (!steady_send)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
            end
        end
    endtask

    // write the column count; only called with nothing in flight
    task automatic write_columns(input logic [ColsW-1:0] cols);
        cfg_valid <= 1'b1;
        columns_in_use <= cols;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cols_setting = cols;
        cfg_writes++;
    endtask

    // stop sending, wait for every expected row, then let the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        stall_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HoldCycles;
            holds_done++;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 60);
            end
            else
                mode_left--;
            case (stall_mode)
                StallNone:  out_stall <= 1'b0;
                StallLight: out_stall <= ($urandom_range(0, 3) == 0);
                StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
                default:    out_stall <= (stall_tick % 5 == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (frame_end)
                frame_ends++;
            if (expected_rows.size() == 0)
            begin
                $error("unexpected result: next_row %h frame_end %b", next_row, frame_end);
                errors++;
            end
            else
            begin
                head = expected_rows.pop_front();
                if (next_row !== head.cells)
                begin
                    $error("next_row: expected %h, got %h", head.cells, next_row);
                    errors++;
                end
                if (row_changed !== head.changed)
                begin
                    $error("row_changed: expected %b, got %b", head.changed, row_changed);
                    errors++;
                end
                if (live_count !== head.count)
                begin
                    $error("live_count: expected %0d, got %0d", head.count, live_count);
                    errors++;
                end
                if (frame_end !== head.last)
                begin
                    $error("frame_end: expected %b, got %b", head.last, frame_end);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted request of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("timeout: %0d rows still expected", expected_rows.size());
            $display("life_row_stencil_engine_unit_test: done, errors");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        dir_row_t         d;
        gen_row_t         typed_res;
        gen_row_t         no_res;
        logic [ColsW-1:0] cols;
        cell_style_t      style;
        int               sent;
        int               height;
        no_res = '{'0, 1'b0, '0, 1'b0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_columns(ColsReset);
        burst_left = $urandom_range(1, 12);

        // directed table at full width
        for (int i = 0; i < DirCount; i++)
        begin
            d = dir_rows[i];
            typed_res = '{d.exp_cells, d.exp_changed, d.exp_count, 1'b1};
            offer_row(d.cells, d.top, d.bottom, d.typed, typed_res);
        end
        wait_drained();

        // random phases, one column setting each, extremes first
        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            case (ph)
                0: cols = 7'd1;
                1: cols = 7'd0;
                2: cols = 7'd127;
                3: cols = 7'd65;
                4: cols = 7'd3;
                5: cols = 7'd63;
                6: cols = 7'd64;
                7: cols = 7'd2;
                default: cols = ColsW'($urandom_range(4, 62));
            endcase
            write_columns(cols);
            sent = 0;

            // back-pressure: output held off while rows keep coming
            if (ph == 3)
            begin
                hold_req = 1'b1;
                steady_send = 1'b1;
                for (int r = 0; r < PressureRow; r++)
                    offer_row(random_cells(StyleRandom), (r % 6) == 0, (r % 6) == 5, 1'b0,
                              no_res);
                steady_send = 1'b0;
                sent = PressureRow;
            end

            while (sent < PhaseRows)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // noise: any flags, any content
                    style = cell_style_t'($urandom_range(0, 4));
                    offer_row(random_cells(style), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b0, no_res);
                    sent++;
                end
                else
                begin
                    // well-formed frame
                    height = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                         : $urandom_range(1, 5);
                    style = cell_style_t'($urandom_range(0, 4));
                    for (int r = 0; r < height; r++)
                        offer_row(random_cells(style), r == 0, r == height - 1, 1'b0, no_res);
                    sent += height;
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (TailWait) @(posedge clk);
        if (expected_rows.size() != 0)
        begin
            $error("%0d expected rows never arrived", expected_rows.size());
            errors++;
        end

        $display("rows sent %0d, rows checked %0d (%0d frame ends), %0d column settings",
                 rows_sent, results_seen, frame_ends, cfg_writes);
        $display("input stalled %0d cycles, %0d long output hold-offs", stall_cycles, holds_done);
        if (errors == 0)
            $display("life_row_stencil_engine_unit_test: done, clean");
        else
            $display("life_row_stencil_engine_unit_test: done, errors");
        $finish;
    end

endmodule

@@ life_row_stencil_engine_unit.f @@
hw/rtl/lrse_pkg.sv
hw/rtl/lrse_lane.sv
hw/rtl/lrse_feed.sv
hw/rtl/lrse_merge.sv
hw/rtl/life_row_stencil_engine_unit.sv
bench/life_row_stencil_engine_unit_test.sv
